// ----- src/eps_pkg.sv -----
package eps_pkg;

   localparam int OP_W     = 2;
   localparam int COST_W   = 31;
   localparam int HANDLE_W = 16;
   localparam int ITER_W   = 24;
   localparam int LIMIT_W  = 5;
   localparam int FILL_W   = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_OFFER     = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
   localparam logic [OP_W-1:0] OP_KEEP_BEST = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [ITER_W-1:0]  ITER_RESET  = 24'd1;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [COST_W-1:0]   offer_cost;
      logic [HANDLE_W-1:0] offer_handle;
      logic [ITER_W-1:0]   offer_iteration;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic                new_best;
      logic                best_valid;
      logic [COST_W-1:0]   best_cost;
      logic [HANDLE_W-1:0] best_handle;
      logic [ITER_W-1:0]   best_iteration;
      logic [FILL_W-1:0]   fill_count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;       // run the request and load the response register
      logic csr_write;  // load the limit register
   } cmd_type;

endpackage

// ----- src/elite_pool_sorted_insert.sv -----
// Sorted top-k pool of (cost, handle) entries, best (lowest cost) at the head.
//
// req_*  : one request per transfer: offer a candidate, clear the pool, or
//          keep only the best entry (see eps_pkg operation codes).
// rsp_*  : exactly one response per request: accepted / new_best flags, the
//          current best entry and its iteration, and the fill count.
// csr_*  : write of the active limit (entries in use). Write only while no
//          request is outstanding; csr_ready is always high.
//
// Latency: the response is registered and valid the cycle after the request
// transfer. Throughput: one request per cycle; every pool cell compares its
// cost against the offer in parallel and the row shifts in one step.
// A response waiting on rsp_ready stalls req_ready; a new request is taken
// in the same cycle the held response transfers.
// Reset (synchronous): pool empty, best iteration 1, limit 16. Entry storage
// is not cleared; only entries below the fill count are ever read.
module elite_pool_sorted_insert #(
   parameter int POOL_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  eps_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output eps_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [eps_pkg::LIMIT_W-1:0]  csr_data
);

   eps_pkg::cmd_type cmd;

   // handshake sequencing
   eps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // compare row, shift row, counters and response register
   eps_dp #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

   // a request transfer always leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   // new_best implies the offer was inserted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_best |-> rsp_data.accepted)
      else $error("new_best without accepted");

   // empty pool reports zero best entry and zero fill
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.best_valid |->
         rsp_data.best_cost == '0 && rsp_data.best_handle == '0 &&
         rsp_data.fill_count == '0)
      else $error("empty pool reports nonzero best");

   // an inserted offer leaves the pool non-empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.best_valid)
      else $error("accepted offer but pool empty");

endmodule

// ----- src/eps_ctrl.sv -----
module eps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              csr_valid,
   output logic              csr_ready,
   output eps_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_EMPTY = 2'b01,
      ST_HOLD  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // a new request may enter as the held response leaves
   assign req_ready     = (state_ff == ST_EMPTY) || rsp_ready;
   assign rsp_valid     = (state_ff == ST_HOLD);
   assign csr_ready     = 1'b1;
   assign cmd.exec      = req_valid && req_ready;
   assign cmd.csr_write = csr_valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EMPTY: begin
            if (cmd.exec) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready && !cmd.exec) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/eps_dp.sv -----
module eps_dp #(
   parameter int POOL_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  eps_pkg::cmd_type             cmd,
   input  eps_pkg::req_type             req_data,
   input  logic [eps_pkg::LIMIT_W-1:0]  csr_data,
   output eps_pkg::rsp_type             rsp_data
);

   localparam int CW = eps_pkg::COST_W;
   localparam int HW = eps_pkg::HANDLE_W;
   localparam int NW = eps_pkg::FILL_W;
   // the limit register is 5 bits, so no more than 31 cells are ever used
   localparam logic [NW:0] DEPTH_CAP = (POOL_DEPTH > 31) ? 6'd31 : 6'(POOL_DEPTH);

   logic [CW-1:0] cost_ff   [POOL_DEPTH];
   logic [CW-1:0] cost_in   [POOL_DEPTH];
   logic [HW-1:0] handle_ff [POOL_DEPTH];
   logic [HW-1:0] handle_in [POOL_DEPTH];

   logic [NW-1:0]                 count_ff, count_in;
   logic [eps_pkg::ITER_W-1:0]    iter_ff, iter_in;
   logic [eps_pkg::LIMIT_W-1:0]   limit_ff;
   eps_pkg::rsp_type              rsp_ff, rsp_in;

   logic [POOL_DEPTH-1:0] valid, lt, eq;
   logic [NW-1:0]         lim;
   logic                  dup, has_room, pos_in, accept, new_best;

   // compare cells: one per entry
   for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
      assign valid[i] = int'(count_ff) > i;
      assign lt[i]    = valid[i] && (cost_ff[i] < req_data.offer_cost);
      assign eq[i]    = valid[i] && (cost_ff[i] == req_data.offer_cost);

      if (i == 0) begin : g_head
         always_comb begin
            if (!accept || lt[i]) begin
               cost_in[i]   = cost_ff[i];
               handle_in[i] = handle_ff[i];
            end else begin
               cost_in[i]   = req_data.offer_cost;
               handle_in[i] = req_data.offer_handle;
            end
         end
      end else begin : g_body
         always_comb begin
            if (!accept || lt[i]) begin
               cost_in[i]   = cost_ff[i];
               handle_in[i] = handle_ff[i];
            end else if (lt[i-1]) begin
               cost_in[i]   = req_data.offer_cost;
               handle_in[i] = req_data.offer_handle;
            end else begin
               cost_in[i]   = cost_ff[i-1];
               handle_in[i] = handle_ff[i-1];
            end
         end
      end
   end

   // effective limit: zero acts as one, clipped to the built depth
   always_comb begin
      if (limit_ff == '0) begin
         lim = NW'(1);
      end else if ({1'b0, limit_ff} > DEPTH_CAP) begin
         lim = DEPTH_CAP[NW-1:0];
      end else begin
         lim = limit_ff;
      end
   end

   always_comb begin
      dup      = |eq;
      has_room = count_ff < lim;
      pos_in   = |(valid & ~lt);
      accept   = (req_data.operation == eps_pkg::OP_OFFER) && !dup && (has_room || pos_in);
      new_best = accept && !lt[0];

      count_in = count_ff;
      iter_in  = iter_ff;
      case (req_data.operation)
         eps_pkg::OP_OFFER: begin
            if (accept && has_room) count_in = count_ff + NW'(1);
            if (new_best)           iter_in  = req_data.offer_iteration;
         end
         eps_pkg::OP_CLEAR: begin
            count_in = '0;
            iter_in  = eps_pkg::ITER_RESET;
         end
         eps_pkg::OP_KEEP_BEST: begin
            if (count_ff != '0) count_in = NW'(1);
         end
         default: ;
      endcase

      rsp_in.accepted       = accept;
      rsp_in.new_best       = new_best;
      rsp_in.best_valid     = (count_in != '0);
      rsp_in.best_cost      = (count_in != '0) ? cost_in[0] : '0;
      rsp_in.best_handle    = (count_in != '0) ? handle_in[0] : '0;
      rsp_in.best_iteration = iter_in;
      rsp_in.fill_count     = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         iter_ff  <= eps_pkg::ITER_RESET;
         limit_ff <= eps_pkg::LIMIT_RESET;
      end else begin
         if (cmd.exec) begin
            count_ff <= count_in;
            iter_ff  <= iter_in;
         end
         if (cmd.csr_write) limit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < POOL_DEPTH; i++) begin
            cost_ff[i]   <= cost_in[i];
            handle_ff[i] <= handle_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- sim/elite_pool_sorted_insert_test.sv -----
`timescale 1ns / 100ps

// Tracks the pool contents and the best iteration, and holds the status that
// each transferred request is due to return, oldest first.
class elite_pool_tracker;
   localparam int DEPTH = 16;

   logic [eps_pkg::COST_W-1:0]   cost_row[DEPTH];
   logic [eps_pkg::HANDLE_W-1:0] handle_row[DEPTH];
   int                           held = 0;
   logic [eps_pkg::ITER_W-1:0]   best_iter = eps_pkg::ITER_RESET;
   logic [eps_pkg::LIMIT_W-1:0]  limit_reg = eps_pkg::LIMIT_RESET;
   eps_pkg::rsp_type             pending_status[$];
   int                           errors = 0;

   function void set_limit(logic [eps_pkg::LIMIT_W-1:0] value);
      limit_reg = value;
   endfunction

   // Apply one request to the pool and queue the status it should produce.
   function void note_request(eps_pkg::req_type r);
      eps_pkg::rsp_type want;
      int               lim;
      int               pos;
      int               fill;
      bit               take;
      logic [31:0]      fill_bits;
      want = '0;
      take = 1'b0;
      pos  = 0;
      lim  = (limit_reg == 0) ? 1 : (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
      case (r.operation)
         eps_pkg::OP_OFFER: begin
            while (pos < held && cost_row[pos] < r.offer_cost)
               pos++;
            take = 1'b1;
            fill = held;
            if (pos < held && cost_row[pos] == r.offer_cost)
               take = 1'b0;
            else if (held < lim)
               fill = held + 1;
            else if (pos >= held)
               take = 1'b0;
            if (take) begin
               // shift worse entries down; the last one falls off when full
               for (int i = fill - 1; i > pos; i--) begin
                  cost_row[i]   = cost_row[i-1];
                  handle_row[i] = handle_row[i-1];
               end
               cost_row[pos]   = r.offer_cost;
               handle_row[pos] = r.offer_handle;
               held            = fill;
               if (pos == 0)
                  best_iter = r.offer_iteration;
            end
         end
         eps_pkg::OP_CLEAR: begin
            held      = 0;
            best_iter = eps_pkg::ITER_RESET;
         end
         eps_pkg::OP_KEEP_BEST: begin
            if (held > 0)
               held = 1;
         end
         default: ;
      endcase
      fill_bits           = held;
      want.accepted       = take;
      want.new_best       = take && pos == 0;
      want.best_valid     = held > 0;
      want.best_cost      = (held > 0) ? cost_row[0] : '0;
      want.best_handle    = (held > 0) ? handle_row[0] : '0;
      want.best_iteration = best_iter;
      want.fill_count     = fill_bits[eps_pkg::FILL_W-1:0];
      pending_status.insert(pending_status.size(), want);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_status(eps_pkg::rsp_type got);
      eps_pkg::rsp_type want;
      if (pending_status.size() == 0) begin
         $display("%0t: unexpected response, expected none actual %p", $time, got);
         errors++;
         return;
      end
      want = pending_status[0];
      pending_status.delete(0);
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("new_best", 32'(want.new_best), 32'(got.new_best));
      compare_field("best_valid", 32'(want.best_valid), 32'(got.best_valid));
      compare_field("best_cost", 32'(want.best_cost), 32'(got.best_cost));
      compare_field("best_handle", 32'(want.best_handle), 32'(got.best_handle));
      compare_field("best_iteration", 32'(want.best_iteration),
                    32'(got.best_iteration));
      compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
   endfunction
endclass

module elite_pool_sorted_insert_test;

   // code 3 is not assigned; the block must leave the pool alone
   localparam logic [eps_pkg::OP_W-1:0]   OP_UNUSED  = 2'd3;
   localparam logic [eps_pkg::COST_W-1:0] COST_MAX   = '1;
   localparam int                STALL_MAX  = 1000;   // cycles with no transfer
   localparam int                PHASES     = 34;
   localparam int                PHASE_ITEMS = 50;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   eps_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   eps_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [eps_pkg::LIMIT_W-1:0] csr_data;

   elite_pool_tracker tracker = new;

   // per-phase idle switches; both off gives back-to-back transfers
   bit               req_idle_on;
   bit               rsp_idle_on;
   int unsigned      falling_cost;
   int               quiet_cycles = 0;

   elite_pool_sorted_insert dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: any transfer on any channel resets the count.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response side: random backpressure, then check each transfer in order.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 4) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         tracker.check_status(rsp_data);
         @(negedge clock);
      end
   end

   // One request transfer. Valid is left high after the transfer; the next
   // call either replaces the payload or drops valid at the next falling edge.
   task automatic send_request(eps_pkg::req_type r);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.note_request(r);
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_status.size() != 0)
         @(posedge clock);
   endtask

   // Limit write; drains every outstanding response first.
   task automatic write_limit(logic [eps_pkg::LIMIT_W-1:0] value);
      hold_until_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      tracker.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic eps_pkg::req_type make_request(
         logic [eps_pkg::OP_W-1:0] op, logic [eps_pkg::COST_W-1:0] cost,
         logic [eps_pkg::HANDLE_W-1:0] handle, logic [eps_pkg::ITER_W-1:0] iter);
      eps_pkg::req_type r;
      r.operation       = op;
      r.offer_cost      = cost;
      r.offer_handle    = handle;
      r.offer_iteration = iter;
      return r;
   endfunction

   task automatic offer(logic [eps_pkg::COST_W-1:0] cost,
                        logic [eps_pkg::HANDLE_W-1:0] handle,
                        logic [eps_pkg::ITER_W-1:0] iter);
      send_request(make_request(eps_pkg::OP_OFFER, cost, handle, iter));
   endtask

   // Random request. Offers dominate; the cost style decides how often
   // offers collide, get rejected, or beat the best.
   function automatic eps_pkg::req_type draw_request(int cost_style);
      eps_pkg::req_type r;
      int               pick;
      logic [31:0]      rnd;
      rnd               = $urandom();
      r.offer_handle    = rnd[eps_pkg::HANDLE_W-1:0];
      rnd               = $urandom();
      r.offer_iteration = rnd[eps_pkg::ITER_W-1:0];
      case (cost_style)
         0: begin
            rnd          = $urandom_range(0, 31);
            r.offer_cost = rnd[eps_pkg::COST_W-1:0];
         end
         1: begin
            rnd          = $urandom_range(0, 4095);
            r.offer_cost = rnd[eps_pkg::COST_W-1:0];
         end
         2: begin
            rnd          = $urandom();
            r.offer_cost = rnd[eps_pkg::COST_W-1:0];
         end
         3: begin
            rnd          = $urandom_range(0, 31);
            r.offer_cost = COST_MAX - rnd[eps_pkg::COST_W-1:0];
         end
         default: begin
            // mostly descending costs, so new bests keep arriving
            if (falling_cost < 64 || $urandom_range(0, 15) == 0)
               falling_cost = $urandom_range(4096, 32'h7fff_ffff);
            falling_cost -= $urandom_range(1, 50);
            rnd          = falling_cost;
            r.offer_cost = rnd[eps_pkg::COST_W-1:0];
         end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 86)
         r.operation = eps_pkg::OP_OFFER;
      else if (pick < 91)
         r.operation = eps_pkg::OP_KEEP_BEST;
      else if (pick < 95)
         r.operation = eps_pkg::OP_CLEAR;
      else
         r.operation = OP_UNUSED;
      return r;
   endfunction

   initial begin
      int style;
      logic [eps_pkg::LIMIT_W-1:0] lim;
      logic [31:0]                 rnd;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      reset       = 1'b1;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // --- directed: reset limit of 16 ---
      send_request(make_request(eps_pkg::OP_KEEP_BEST, '0, '0, '0)); // empty pool
      offer(COST_MAX, 16'hffff, 24'hffffff);                      // first entry, new best
      offer('0, '0, '0);                                          // cheapest possible
      offer('0, 16'h1234, 24'h000042);                            // equal cost: rejected
      offer(COST_MAX, 16'h5678, 24'h000043);                      // equal to worst: rejected
      send_request(make_request(OP_UNUSED, 31'h2aaa_aaaa, 16'h5555, 24'haaaaaa));
      offer(31'd500, 16'h00aa, 24'h000050);
      send_request(make_request(eps_pkg::OP_KEEP_BEST, 31'd7, 16'h7, 24'h7));
      send_request(make_request(eps_pkg::OP_CLEAR, 31'd9, 16'h9, 24'h9));

      // --- directed: small pool, full-pool rejects and evictions ---
      write_limit(5'd4);
      offer(31'd40, 16'd1, 24'd10);
      offer(31'd30, 16'd2, 24'd11);
      offer(31'd20, 16'd3, 24'd12);
      offer(31'd10, 16'd4, 24'd13);
      offer(31'd50, 16'd5, 24'd14);                                // full, worse than worst
      offer(31'd40, 16'd6, 24'd15);                                // full, equal to worst
      offer(31'd25, 16'd7, 24'd16);                                // evicts 40
      offer(31'd5, 16'd8, 24'd17);                                 // new best, evicts 30
      // limit below fill: entries kept, an insert drops only one
      write_limit(5'd2);
      offer(31'd15, 16'd9, 24'd18);
      offer(31'd100, 16'd10, 24'd19);
      // a limit of zero acts as one
      write_limit(5'd0);
      offer(31'd1, 16'd11, 24'd20);
      send_request(make_request(eps_pkg::OP_KEEP_BEST, '0, '0, '0));
      offer(31'd2, 16'd12, 24'd21);                                // full at one, worse
      offer(31'd0, 16'd13, 24'd22);                                // replaces the only entry
      send_request(make_request(eps_pkg::OP_CLEAR, '0, '0, '0));

      // --- random phases; each starts drained with a new limit ---
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 6)
            0: lim = 5'd16;
            1: lim = 5'd1;
            2: lim = 5'd0;
            3: lim = 5'd31;
            4: begin
               rnd = $urandom_range(2, 6);
               lim = rnd[eps_pkg::LIMIT_W-1:0];
            end
            default: begin
               rnd = $urandom_range(0, 31);
               lim = rnd[eps_pkg::LIMIT_W-1:0];
            end
         endcase
         write_limit(lim);
         if (phase % 5 == 4) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on = $urandom_range(0, 3) != 0;
         end
         style = phase % 5;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) == 0)
               hold_until_drained();
            send_request(draw_request(style));
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (tracker.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
